FILE: design/ndc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ndc_pkg;

	// Format codes
	localparam logic [1:0] FMT_UNSIGNED = 2'd0;
	localparam logic [1:0] FMT_SIGNED   = 2'd1;
	localparam logic [1:0] FMT_HEX      = 2'd2;

	// Character codes
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;

	localparam int DEC_DIGITS = 5;
	localparam int HEX_DIGITS = 4;
	localparam int SLOTS      = 7;

	// 100000 = 2^5 * 3125. The low five bits pass straight through and the
	// rest is reduced modulo 3125 with a reciprocal multiply.
	localparam int              LOW_BITS  = 5;
	localparam int              X_W       = 32 - LOW_BITS;
	localparam int              M_W       = 28;
	localparam int              P_W       = X_W + M_W;
	localparam int              Q_W       = 16;
	localparam int              R_W       = 12;
	localparam int              REC_SHIFT = 39;
	localparam logic [M_W-1:0]  REC_M     = 28'd175921861;
	localparam logic [R_W-1:0]  DIV_ODD   = 12'd3125;

	// Remainder modulo 100000 fits in 17 bits.
	localparam int REM_W = R_W + LOW_BITS;

	typedef struct packed {
		logic [1:0] fmt;
		logic [2:0] count;
		logic       neg;
		logic [7:0] cmd;
	} ctl_t;

	typedef struct packed {
		logic       is_command;
		logic [7:0] code;
	} res_t;

	function automatic logic [REM_W-1:0] dec_weight(input logic [2:0] pos);
		logic [REM_W-1:0] w;
		unique case (pos)
			3'd0:    w = 17'd1;
			3'd1:    w = 17'd10;
			3'd2:    w = 17'd100;
			3'd3:    w = 17'd1000;
			3'd4:    w = 17'd10000;
			default: w = 17'd1;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'd0, d};
		end else begin
			c = CHAR_UPPER_A + {4'd0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: design/number_to_display_chars.sv
`timescale 1ns / 1ps
`default_nettype none

// Formats one 32-bit number into the bytes sent to a character display.
// Input channel: in_valid / in_stall carry format_kind, digit_count, value
// and cursor_command. An item is taken at a clock edge where in_valid is
// high and in_stall is low.
// Output channel: out_valid / out_stall carry one byte per item: the cursor
// command first (is_command high), then the sign in signed decimal, then the
// low digit_count digits, most significant first. last marks the final byte.
// Throughput: a number is 1 to 7 bytes long on the output, sent one byte
// per cycle while out_stall is low; the output byte rate is the limit, the
// eight-stage front pipeline takes a new number every cycle while there is
// room.
// The decimal path reduces the value modulo 100000 with one reciprocal
// multiply stage and one multiply-subtract stage, then peels one decimal
// digit per stage by parallel compares.
// Reset clears all valid flags; no bytes are pending afterwards.
// When the receiver stalls, the current byte holds, the pipeline fills, and
// once it is full in_stall rises until bytes drain again.

module number_to_display_chars
	import ndc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  format_kind,
	input  wire logic [2:0]  digit_count,
	input  wire logic [31:0] value,
	input  wire logic [7:0]  cursor_command,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             is_command,
	output logic      [7:0]  char_code,
	output logic             last
);

	// Stage valid flags and the per-stage ready chain.
	logic [8:1] vld_s;
	logic [8:1] rdy;
	logic       ser_rdy;

	ctl_t                  ctl_s [1:8];
	logic [31:0]           val_s1;
	logic [31:0]           mag_s2;
	logic [P_W-1:0]        prod_s3;
	logic [X_W-1:0]        xr_s3;
	logic [LOW_BITS-1:0]   low_s3;
	logic [15:0]           hex_s [3:8];
	logic [REM_W-1:0]      rem_s [4:8];
	logic [4:1][3:0]       dec_s [4:8];

	logic                  neg_a;
	logic [31:0]           mag_a;
	logic [Q_W-1:0]        q_c;
	logic [Q_W+R_W-1:0]    qm_c;
	logic [X_W-1:0]        r_c;
	logic [3:0]            dig_w [5:8];
	logic [REM_W-1:0]      remn_w [5:8];
	logic [4:0][7:0]       chars;

	// A stage can take new data when it is empty or its content moves on.
	always_comb begin
		rdy[8] = !vld_s[8] || ser_rdy;
		for (int i = 7; i >= 1; i--) begin
			rdy[i] = !vld_s[i] || rdy[i+1];
		end
	end

	assign in_stall = !rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int i = 2; i <= 8; i++) begin
				if (rdy[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// Stage 1: input register.
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			ctl_s[1] <= '{fmt: format_kind, count: digit_count, neg: 1'b0,
				cmd: cursor_command};
			val_s1   <= value;
		end
	end

	// Stage 2: sign and magnitude. The most negative value wraps onto its
	// own unsigned magnitude.
	assign neg_a = (ctl_s[1].fmt == FMT_SIGNED) && val_s1[31];
	assign mag_a = neg_a ? (32'd0 - val_s1) : val_s1;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			ctl_s[2] <= '{fmt: ctl_s[1].fmt, count: ctl_s[1].count, neg: neg_a,
				cmd: ctl_s[1].cmd};
			mag_s2   <= mag_a;
		end
	end

	// Stage 3: quotient of the upper bits by 3125 via reciprocal multiply.
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			ctl_s[3] <= ctl_s[2];
			prod_s3  <= {{M_W{1'b0}}, mag_s2[31:LOW_BITS]} * {{X_W{1'b0}}, REC_M};
			xr_s3    <= mag_s2[31:LOW_BITS];
			low_s3   <= mag_s2[LOW_BITS-1:0];
			hex_s[3] <= mag_s2[15:0];
		end
	end

	// Stage 4: remainder modulo 3125, then joined with the low bits to give
	// the value modulo 100000.
	assign q_c  = prod_s3[REC_SHIFT +: Q_W];
	assign qm_c = {{R_W{1'b0}}, q_c} * {{Q_W{1'b0}}, DIV_ODD};
	assign r_c  = xr_s3 - qm_c[X_W-1:0];

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			ctl_s[4] <= ctl_s[3];
			hex_s[4] <= hex_s[3];
			rem_s[4] <= {r_c[R_W-1:0], low_s3};
			dec_s[4] <= '0;
		end
	end

	// Stages 5 to 8: one decimal digit each, most significant first. What
	// remains after the last of them is the units digit.
	for (genvar g = 0; g < 4; g++) begin : g_dig
		localparam int ST = 5 + g;

		logic [4:1][3:0] dec_n;

		ndc_digit_stage #(
			.POS(4 - g)
		) u_dig (
			.rem_in (rem_s[ST-1]),
			.digit  (dig_w[ST]),
			.rem_out(remn_w[ST])
		);

		// Digits found so far, with this stage's digit dropped into place.
		always_comb begin
			dec_n        = dec_s[ST-1];
			dec_n[4 - g] = dig_w[ST];
		end

		always_ff @(posedge clk) begin
			if (rdy[ST]) begin
				ctl_s[ST] <= ctl_s[ST-1];
				hex_s[ST] <= hex_s[ST-1];
				rem_s[ST] <= remn_w[ST];
				dec_s[ST] <= dec_n;
			end
		end
	end

	// Character for every digit position, decimal or hex. Hex never shows
	// the fifth position.
	always_comb begin
		chars[0] = CHAR_ZERO + {4'd0, rem_s[8][3:0]};
		for (int p = 1; p < DEC_DIGITS; p++) begin
			chars[p] = CHAR_ZERO + {4'd0, dec_s[8][p]};
		end
		if (ctl_s[8].fmt == FMT_HEX) begin
			chars[DEC_DIGITS-1] = CHAR_ZERO;
			for (int p = 0; p < HEX_DIGITS; p++) begin
				chars[p] = hex_char(hex_s[8][p*4 +: 4]);
			end
		end
	end

	ndc_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (vld_s[8] && ser_rdy),
		.ctl       (ctl_s[8]),
		.chars     (chars),
		.ready     (ser_rdy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_command(is_command),
		.char_code (char_code),
		.last      (last)
	);

endmodule

`default_nettype wire

FILE: design/ndc_digit_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ndc_digit_stage
	import ndc_pkg::*;
#(
	parameter int POS = 4
) (
	input  wire logic [REM_W-1:0] rem_in,
	output logic      [3:0]       digit,
	output logic      [REM_W-1:0] rem_out
);

	localparam logic [REM_W-1:0] W = dec_weight(3'(POS));

	logic [8:0]       ge;
	logic [REM_W-1:0] sub;

	// The input is below ten times the weight, so the digit is the number
	// of multiples of the weight that do not exceed it.
	always_comb begin
		sub = '0;
		for (int k = 1; k <= 9; k++) begin
			ge[k-1] = rem_in >= (REM_W'(k) * W);
			if (ge[k-1]) begin
				sub = REM_W'(k) * W;
			end
		end
		digit   = 4'($countones(ge));
		rem_out = rem_in - sub;
	end

endmodule

`default_nettype wire

FILE: design/ndc_serializer.sv
`timescale 1ns / 1ps
`default_nettype none

module ndc_serializer
	import ndc_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire ctl_t            ctl,
	input  wire logic [4:0][7:0] chars,
	output logic                 ready,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 is_command,
	output logic      [7:0]      char_code,
	output logic                 last
);

	res_t       buf_q [SLOTS];
	logic [2:0] cnt_q;

	res_t       fill [SLOTS];
	logic [2:0] fill_cnt;
	logic [2:0] nd;
	logic       sgn;
	logic [2:0] k;
	logic [2:0] pos;
	logic       take;

	assign out_valid  = cnt_q != 3'd0;
	assign is_command = buf_q[0].is_command;
	assign char_code  = buf_q[0].code;
	assign last       = cnt_q == 3'd1;
	assign take       = out_valid && !out_stall;
	assign ready      = (cnt_q == 3'd0) || (last && take);

	always_comb begin
		sgn = ctl.fmt == FMT_SIGNED;
		case (ctl.fmt) inside
			FMT_UNSIGNED, FMT_SIGNED: begin
				nd = (ctl.count >= 3'd1 && ctl.count <= 3'(DEC_DIGITS)) ? ctl.count : 3'd0;
			end
			FMT_HEX: begin
				nd = (ctl.count >= 3'd1 && ctl.count <= 3'(HEX_DIGITS)) ? ctl.count : 3'd0;
			end
			default: begin
				nd = 3'd0;
			end
		endcase

		fill[0]  = '{is_command: 1'b1, code: ctl.cmd};
		fill_cnt = 3'd1 + {2'd0, sgn} + nd;
		k        = '0;
		pos      = '0;
		for (int j = 1; j < SLOTS; j++) begin
			fill[j] = '{is_command: 1'b0, code: CHAR_ZERO};
			if (sgn && j == 1) begin
				fill[j].code = ctl.neg ? CHAR_MINUS : CHAR_PLUS;
			end else begin
				k = 3'(j) - 3'd1 - {2'd0, sgn};
				if (k < nd) begin
					pos          = nd - 3'd1 - k;
					fill[j].code = chars[pos];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= fill_cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= fill;
		end else if (take) begin
			for (int j = 0; j < SLOTS - 1; j++) begin
				buf_q[j] <= buf_q[j+1];
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/ndc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ndc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       is_command,
	input wire logic [7:0] char_code,
	input wire logic       last
);

	logic       mid_q;
	logic [2:0] len_q;
	logic [3:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q  <= 1'b0;
			len_q  <= 3'd0;
			pend_q <= 4'd0;
		end else begin
			if (out_acc) begin
				mid_q <= !last;
				len_q <= last ? 3'd0 : len_q + 3'd1;
			end
			pend_q <= pend_q + {3'd0, in_acc} - {3'd0, out_acc && last};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code)
			&& $stable(is_command) && $stable(last))
		else $error("stalled output byte changed");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mid_q |-> is_command)
		else $error("number does not start with the cursor command");

	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mid_q |-> !is_command)
		else $error("cursor command inside a number");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && len_q == 3'd6 |-> last)
		else $error("number longer than seven bytes");

	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("output byte without a pending input item");

endmodule

bind number_to_display_chars ndc_checker u_chk (.*);

`default_nettype wire

FILE: dv/number_to_display_chars_test.sv
`timescale 1ns / 1ps

// Testbench for number_to_display_chars.
//
// Every number that the block accepts is run through a predictor in this
// file. The predictor queues the bytes that the display should receive for
// that number. A separate process takes each byte that leaves the block,
// compares it field by field with the oldest queued byte, and flags extra
// or wrong bytes. Bytes still queued at the end of the run are failures.
//
// The block keeps no state that carries from one number to the next. The run
// therefore consists of a directed set of corner numbers, random numbers
// under several idling mixes on both channels, and one long receiver
// hold-off that fills the pipeline and forces in_stall high.

module number_to_display_chars_test;
	import ndc_pkg::*;

	// The format field has a fourth code that the block treats as unknown.
	localparam logic [1:0] FMT_UNKNOWN = 2'd3;

	// Cycles the block may still need after the last expected byte.
	localparam int DRAIN_CYCLES = 20;
	// Upper bound on cycles spent waiting for outstanding bytes at the end.
	localparam int DRAIN_LIMIT = 20000;

	// One byte as seen on the output channel.
	typedef struct packed {
		logic       is_cmd;
		logic [7:0] code;
		logic       last;
	} disp_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  format_kind = '0;
	logic [2:0]  digit_count = '0;
	logic [31:0] value = '0;
	logic [7:0]  cursor_command = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        is_command;
	logic [7:0]  char_code;
	logic        last;

	// Bytes the display should still receive, oldest first.
	disp_char_t expected_chars[$];
	bit failed = 1'b0;

	// Idling mix: chance in percent that the sender idles, or the receiver
	// stalls, in a given cycle. These only change right after a rising edge.
	int idle_pct = 0;
	int stall_pct = 0;
	// Cycles the receiver still has to hold off. The test sets it right after
	// a rising edge; the receiver counts it down at falling edges.
	int holdoff_cycles = 0;

	number_to_display_chars dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.format_kind    (format_kind),
		.digit_count    (digit_count),
		.value          (value),
		.cursor_command (cursor_command),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.is_command     (is_command),
		.char_code      (char_code),
		.last           (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Works out the bytes for one number and appends them to the queue of
	// expected bytes. The command byte always comes first. Signed decimal adds
	// a sign and shows the magnitude. Only the low digits are kept, so the
	// leading digit wraps. Digit counts out of range for the format give no
	// digits at all, and the unknown format gives the command byte alone.
	function automatic void predict_chars(input logic [1:0] fmt, input logic [2:0] cnt,
			input logic [31:0] val, input logic [7:0] cmd);
		disp_char_t seq[$];
		logic [31:0] mag;
		logic [31:0] weight;
		logic [3:0]  dgt;
		mag = val;
		seq.push_back('{is_cmd: 1'b1, code: cmd, last: 1'b0});
		if (fmt == FMT_SIGNED) begin
			if (val[31]) begin
				seq.push_back('{is_cmd: 1'b0, code: CHAR_MINUS, last: 1'b0});
				mag = 32'd0 - val;
			end else begin
				seq.push_back('{is_cmd: 1'b0, code: CHAR_PLUS, last: 1'b0});
			end
		end
		if ((fmt == FMT_UNSIGNED || fmt == FMT_SIGNED) && cnt >= 3'd1 && cnt <= 3'd5) begin
			for (int pos = int'(cnt) - 1; pos >= 0; pos--) begin
				weight = 32'd1;
				repeat (pos) weight = weight * 32'd10;
				dgt = 4'((mag / weight) % 32'd10);
				seq.push_back('{is_cmd: 1'b0, code: CHAR_ZERO + {4'd0, dgt}, last: 1'b0});
			end
		end else if (fmt == FMT_HEX && cnt >= 3'd1 && cnt <= 3'd4) begin
			for (int pos = int'(cnt) - 1; pos >= 0; pos--) begin
				dgt = 4'(mag >> (4 * pos));
				if (dgt < 4'd10) begin
					seq.push_back('{is_cmd: 1'b0, code: CHAR_ZERO + {4'd0, dgt},
						last: 1'b0});
				end else begin
					seq.push_back('{is_cmd: 1'b0, code: CHAR_UPPER_A + {4'd0, dgt} - 8'd10,
						last: 1'b0});
				end
			end
		end
		seq[seq.size() - 1].last = 1'b1;
		foreach (seq[i]) expected_chars.push_back(seq[i]);
	endfunction

	// Offers one number to the block, idling first as the current mix asks.
	// Fields change only at falling edges and stay put while in_stall holds
	// the item. The task returns just after the rising edge that took it, with
	// in_valid still high, so back-to-back numbers leave no gap.
	task automatic send_number(input logic [1:0] fmt, input logic [2:0] cnt,
			input logic [31:0] val, input logic [7:0] cmd);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		format_kind    <= fmt;
		digit_count    <= cnt;
		value          <= val;
		cursor_command <= cmd;
		in_valid       <= 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		predict_chars(fmt, cnt, val, cmd);
	endtask

	// Receiver: a pending hold-off wins; otherwise stall at random.
	always @(negedge clk) begin
		if (holdoff_cycles > 0) begin
			out_stall <= 1'b1;
			holdoff_cycles = holdoff_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Checks every byte that the display takes against the oldest expected
	// byte.
	always @(posedge clk) begin
		disp_char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected byte: is_command %0b, char_code 0x%02h, last %0b",
					is_command, char_code, last);
				failed = 1'b1;
			end else begin
				want = expected_chars.pop_front();
				if (is_command !== want.is_cmd) begin
					$error("is_command: expected %0b, got %0b", want.is_cmd, is_command);
					failed = 1'b1;
				end
				if (char_code !== want.code) begin
					$error("char_code: expected 0x%02h, got 0x%02h", want.code, char_code);
					failed = 1'b1;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					failed = 1'b1;
				end
			end
		end
	end

	// Corner numbers: every format including the unknown code, every digit
	// count from zero to seven, the extremes of the value and of the command
	// byte, the most negative value in signed decimal, leading digits that
	// wrap, and hex with five digits.
	task automatic test_directed_cases();
		send_number(FMT_UNSIGNED, 3'd5, 32'd0, 8'h80);
		send_number(FMT_UNSIGNED, 3'd5, 32'hFFFF_FFFF, 8'hFF);
		send_number(FMT_UNSIGNED, 3'd1, 32'hFFFF_FFFF, 8'h00);
		send_number(FMT_UNSIGNED, 3'd5, 32'd123456, 8'h10);
		send_number(FMT_UNSIGNED, 3'd3, 32'd99999, 8'hC0);
		send_number(FMT_UNSIGNED, 3'd0, 32'd42, 8'h01);
		send_number(FMT_UNSIGNED, 3'd6, 32'd42, 8'h02);
		send_number(FMT_UNSIGNED, 3'd7, 32'd42, 8'h03);
		send_number(FMT_SIGNED, 3'd5, 32'd0, 8'h80);
		send_number(FMT_SIGNED, 3'd5, 32'h7FFF_FFFF, 8'h81);
		send_number(FMT_SIGNED, 3'd5, 32'h8000_0000, 8'h82);
		send_number(FMT_SIGNED, 3'd3, 32'hFFFF_FFFF, 8'h83);
		send_number(FMT_SIGNED, 3'd4, 32'hFFFF_D8F1, 8'h84);
		send_number(FMT_SIGNED, 3'd0, 32'hFFFF_FFF6, 8'h85);
		send_number(FMT_SIGNED, 3'd7, 32'd17, 8'h86);
		send_number(FMT_HEX, 3'd4, 32'hDEAD_BEEF, 8'h90);
		send_number(FMT_HEX, 3'd4, 32'h1234_ABCD, 8'h91);
		send_number(FMT_HEX, 3'd1, 32'hFFFF_FFFF, 8'h92);
		send_number(FMT_HEX, 3'd5, 32'h0000_5678, 8'h93);
		send_number(FMT_HEX, 3'd0, 32'h8000_0000, 8'h94);
		send_number(FMT_HEX, 3'd6, 32'h0000_0009, 8'h95);
		send_number(FMT_UNKNOWN, 3'd4, 32'd1234, 8'hA0);
		send_number(FMT_UNKNOWN, 3'd2, 32'hFFFF_FFFF, 8'hFF);
	endtask

	// Values biased toward the interesting regions: full range, small
	// positives, small negatives, around the most negative value, near the
	// top of the range, and single hex digits at random positions.
	function automatic logic [31:0] random_value();
		logic [31:0] v;
		case ($urandom_range(5))
			0: v = $urandom();
			1: v = $urandom_range(99999);
			2: v = 32'd0 - 32'($urandom_range(99999));
			3: v = 32'h8000_0000 + 32'($urandom_range(255));
			4: v = 32'hFFFF_FFFF - 32'($urandom_range(255));
			default: v = 32'($urandom_range(15)) << (4 * $urandom_range(7));
		endcase
		return v;
	endfunction

	// Mostly well-formed numbers with a digit count that suits the format.
	// About one in eight gets any digit count, and about one in twenty the
	// unknown format code.
	task automatic test_random_numbers(input int count);
		logic [1:0] fmt;
		logic [2:0] cnt;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(19);
			if (pick == 0) begin
				fmt = FMT_UNKNOWN;
			end else if (pick % 3 == 0) begin
				fmt = FMT_UNSIGNED;
			end else if (pick % 3 == 1) begin
				fmt = FMT_SIGNED;
			end else begin
				fmt = FMT_HEX;
			end
			if ($urandom_range(7) == 0) begin
				cnt = 3'($urandom_range(7));
			end else if (fmt == FMT_HEX) begin
				cnt = 3'($urandom_range(1, 4));
			end else begin
				cnt = 3'($urandom_range(1, 5));
			end
			send_number(fmt, cnt, random_value(), 8'($urandom()));
		end
	endtask

	// The receiver holds off for a long stretch while numbers keep coming, so
	// the pipeline fills and in_stall has to hold the sender back.
	task automatic test_output_holdoff();
		idle_pct = 0;
		stall_pct = 0;
		send_number(FMT_SIGNED, 3'd5, 32'hFFFE_7961, 8'h80);
		holdoff_cycles = 150;
		test_random_numbers(30);
	endtask

	// Stops the stimulus, waits for the outstanding bytes, watches DRAIN_CYCLES
	// more for anything stray, and reports.
	task automatic finish_run();
		int waited;
		waited = 0;
		idle_pct = 0;
		stall_pct = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_chars.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_chars.size() != 0) begin
			$error("%0d expected bytes never arrived", expected_chars.size());
			failed = 1'b1;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed) begin
			$display("number_to_display_chars_test passed");
		end else begin
			$display("number_to_display_chars_test failed");
		end
		$finish;
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// No idling on either side.
		test_directed_cases();
		test_random_numbers(42);

		// Sender mostly idle.
		idle_pct = 83;
		test_random_numbers(42);

		// Receiver mostly stalling.
		idle_pct = 0;
		stall_pct = 83;
		test_random_numbers(42);

		// Light idling on both sides.
		idle_pct = 16;
		stall_pct = 16;
		test_random_numbers(42);

		test_output_holdoff();
		finish_run();
	end

	// A hang anywhere ends the run as a failure.
	initial begin
		#5000000;
		$display("number_to_display_chars_test failed");
		$finish;
	end

endmodule
